FILE: sv/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, operation codes, angle table and the iteration item type for the
// complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned ProdW       = 64;
  localparam int unsigned SumW        = ProdW + 1;
  localparam int unsigned QuotW       = 34;
  localparam int unsigned DivFrac     = 17;
  localparam int unsigned SqrtSteps   = ProdW / 2;
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned IterStages  = QuotW;
  localparam int unsigned CordW       = 36;
  localparam int unsigned AngW        = 24;
  localparam int unsigned RndW        = SumW - 16;
  localparam int unsigned ActW        = 3;

  localparam logic [ActW-1:0] ACT_ADD = 3'd0;
  localparam logic [ActW-1:0] ACT_SUB = 3'd1;
  localparam logic [ActW-1:0] ACT_MUL = 3'd2;
  localparam logic [ActW-1:0] ACT_DIV = 3'd3;
  localparam logic [ActW-1:0] ACT_MOD = 3'd4;
  localparam logic [ActW-1:0] ACT_ARG = 3'd5;

  localparam logic signed [AngW-1:0] ANG_HALF_PI = 24'sd1647099;

  typedef struct packed {
    logic [ActW-1:0]          act;
    logic [DataW-1:0]         as_re;
    logic [DataW-1:0]         as_im;
    logic                     as_sat;
    logic                     n_re_neg;
    logic [ProdW-1:0]         n_re_mag;
    logic                     n_im_neg;
    logic [ProdW-1:0]         n_im_mag;
    logic [ProdW-1:0]         d;
    logic                     dz;
    logic [ProdW-1:0]         rem_re;
    logic [ProdW-1:0]         rem_im;
    logic [QuotW-1:0]         q_re;
    logic [QuotW-1:0]         q_im;
    logic                     ovf_re;
    logic                     ovf_im;
    logic [ProdW-1:0]         sq_res;
    logic [ProdW-1:0]         sq_rem;
    logic signed [CordW-1:0]  cx;
    logic signed [CordW-1:0]  cy;
    logic signed [AngW-1:0]   cz;
    logic                     c_zero;
  } iter_t;

  function automatic logic signed [AngW-1:0] atan_lut(input int unsigned idx);
    logic signed [AngW-1:0] v;
    case (idx)
      0:       v = 24'sd823550;
      1:       v = 24'sd486170;
      2:       v = 24'sd256879;
      3:       v = 24'sd130396;
      4:       v = 24'sd65451;
      5:       v = 24'sd32757;
      6:       v = 24'sd16383;
      7:       v = 24'sd8192;
      8:       v = 24'sd4096;
      9:       v = 24'sd2048;
      10:      v = 24'sd1024;
      11:      v = 24'sd512;
      12:      v = 24'sd256;
      13:      v = 24'sd128;
      14:      v = 24'sd64;
      15:      v = 24'sd32;
      16:      v = 24'sd16;
      17:      v = 24'sd8;
      18:      v = 24'sd4;
      19:      v = 24'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // sign/magnitude to Q16.16 with clipping; returns {sat, value}
  function automatic logic [DataW:0] sm_to_q(input logic neg, input logic [RndW-1:0] mag);
    logic [DataW:0]  r;
    logic [RndW-1:0] lim_n;
    logic [RndW-1:0] lim_p;
    lim_n = {{(RndW-DataW){1'b0}}, 1'b1, {(DataW-1){1'b0}}};
    lim_p = {{(RndW-DataW){1'b0}}, 1'b0, {(DataW-1){1'b1}}};
    if (neg) begin
      if (mag > lim_n) begin
        r = {1'b1, lim_n[DataW-1:0]};
      end else begin
        r = {1'b0, DataW'(RndW'(0) - mag)};
      end
    end else begin
      if (mag > lim_p) begin
        r = {1'b1, lim_p[DataW-1:0]};
      end else begin
        r = {1'b0, mag[DataW-1:0]};
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/cau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_req_if / cau_rsp_if
// Valid/ready channels carrying operation items and result items.
// ----------------------------------------------------------------------------
interface cau_req_if import cau_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ActW-1:0]         action;
  logic signed [DataW-1:0] a_re;
  logic signed [DataW-1:0] a_im;
  logic signed [DataW-1:0] b_re;
  logic signed [DataW-1:0] b_im;

  modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if import cau_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] res_re;
  logic signed [DataW-1:0] res_im;
  logic                    div_by_zero;
  logic                    saturated;

  modport source (output valid, res_re, res_im, div_by_zero, saturated, input ready);
  modport sink   (input valid, res_re, res_im, div_by_zero, saturated, output ready);
endinterface

FILE: sv/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Four front stages: products and add/sub, sums, magnitudes, divider and
// square root setup.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  cau_req_if.sink req_i,
  output logic  vld_o,
  input  logic  rdy_i,
  output iter_t data_o
);

  typedef struct packed {
    logic [ActW-1:0]         act;
    logic [DataW-1:0]        as_re;
    logic [DataW-1:0]        as_im;
    logic                    as_sat;
    logic signed [ProdW-1:0] m0;
    logic signed [ProdW-1:0] m1;
    logic signed [ProdW-1:0] m2;
    logic signed [ProdW-1:0] m3;
    logic [ProdW-1:0]        b2r;
    logic [ProdW-1:0]        b2i;
    logic signed [CordW-1:0] cx;
    logic signed [CordW-1:0] cy;
    logic signed [AngW-1:0]  cz;
    logic                    c_zero;
  } f1_t;

  typedef struct packed {
    logic [ActW-1:0]         act;
    logic [DataW-1:0]        as_re;
    logic [DataW-1:0]        as_im;
    logic                    as_sat;
    logic signed [SumW-1:0]  n_re;
    logic signed [SumW-1:0]  n_im;
    logic [ProdW-1:0]        d;
    logic signed [CordW-1:0] cx;
    logic signed [CordW-1:0] cy;
    logic signed [AngW-1:0]  cz;
    logic                    c_zero;
  } f2_t;

  function automatic logic [DataW:0] clip33(input logic [DataW:0] v);
    logic [DataW:0] r;
    if (v[DataW] != v[DataW-1]) begin
      r = {1'b1, v[DataW], {(DataW-1){!v[DataW]}}};
    end else begin
      r = {1'b0, v[DataW-1:0]};
    end
    return r;
  endfunction

  f1_t   f1_d, f1_q;
  f2_t   f2_d, f2_q;
  iter_t f3_d, f3_q;
  iter_t f4_d, f4_q;
  logic  v1_q, v2_q, v3_q, v4_q;
  logic  rdy1, rdy2, rdy3, rdy4;

  assign rdy4        = !v4_q || rdy_i;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign req_i.ready = rdy1;
  assign vld_o       = v4_q;
  assign data_o      = f4_q;

  logic signed [DataW-1:0] ar, ai, br, bi, op0, op1;
  logic signed [CordW-1:0] ar_x, ai_x;
  logic [DataW:0]          s_re, s_im, c_re, c_im;

  always_comb begin
    ar   = req_i.a_re;
    ai   = req_i.a_im;
    br   = req_i.b_re;
    bi   = req_i.b_im;
    op0  = (req_i.action == ACT_MOD) ? ar : br;
    op1  = (req_i.action == ACT_MOD) ? ai : bi;
    ar_x = {{(CordW-DataW){ar[DataW-1]}}, ar};
    ai_x = {{(CordW-DataW){ai[DataW-1]}}, ai};
    if (req_i.action == ACT_SUB) begin
      s_re = {ar[DataW-1], ar} - {br[DataW-1], br};
      s_im = {ai[DataW-1], ai} - {bi[DataW-1], bi};
    end else begin
      s_re = {ar[DataW-1], ar} + {br[DataW-1], br};
      s_im = {ai[DataW-1], ai} + {bi[DataW-1], bi};
    end
    c_re = clip33(s_re);
    c_im = clip33(s_im);

    f1_d.act    = req_i.action;
    f1_d.as_re  = c_re[DataW-1:0];
    f1_d.as_im  = c_im[DataW-1:0];
    f1_d.as_sat = c_re[DataW] | c_im[DataW];
    f1_d.m0     = ar * op0;
    f1_d.m1     = ai * op1;
    f1_d.m2     = ar * bi;
    f1_d.m3     = ai * br;
    f1_d.b2r    = ProdW'(br) * ProdW'(br);
    f1_d.b2i    = ProdW'(bi) * ProdW'(bi);
    f1_d.c_zero = (ar == '0) && (ai == '0);
    if (ar[DataW-1]) begin
      if (!ai[DataW-1]) begin
        f1_d.cx = ai_x;
        f1_d.cy = -ar_x;
        f1_d.cz = ANG_HALF_PI;
      end else begin
        f1_d.cx = -ai_x;
        f1_d.cy = ar_x;
        f1_d.cz = -ANG_HALF_PI;
      end
    end else begin
      f1_d.cx = ar_x;
      f1_d.cy = ai_x;
      f1_d.cz = '0;
    end
  end

  logic signed [SumW-1:0] e0, e1, e2, e3;

  always_comb begin
    e0 = {f1_q.m0[ProdW-1], f1_q.m0};
    e1 = {f1_q.m1[ProdW-1], f1_q.m1};
    e2 = {f1_q.m2[ProdW-1], f1_q.m2};
    e3 = {f1_q.m3[ProdW-1], f1_q.m3};
    f2_d.act    = f1_q.act;
    f2_d.as_re  = f1_q.as_re;
    f2_d.as_im  = f1_q.as_im;
    f2_d.as_sat = f1_q.as_sat;
    f2_d.n_re   = (f1_q.act == ACT_MUL) ? (e0 - e1) : (e0 + e1);
    f2_d.n_im   = (f1_q.act == ACT_MUL) ? (e2 + e3) : (e3 - e2);
    f2_d.d      = f1_q.b2r + f1_q.b2i;
    f2_d.cx     = f1_q.cx;
    f2_d.cy     = f1_q.cy;
    f2_d.cz     = f1_q.cz;
    f2_d.c_zero = f1_q.c_zero;
  end

  always_comb begin
    f3_d          = '0;
    f3_d.act      = f2_q.act;
    f3_d.as_re    = f2_q.as_re;
    f3_d.as_im    = f2_q.as_im;
    f3_d.as_sat   = f2_q.as_sat;
    f3_d.n_re_neg = f2_q.n_re[SumW-1];
    f3_d.n_re_mag = ProdW'(f2_q.n_re[SumW-1] ? -f2_q.n_re : f2_q.n_re);
    f3_d.n_im_neg = f2_q.n_im[SumW-1];
    f3_d.n_im_mag = ProdW'(f2_q.n_im[SumW-1] ? -f2_q.n_im : f2_q.n_im);
    f3_d.d        = f2_q.d;
    f3_d.dz       = (f2_q.d == '0);
    f3_d.cx       = f2_q.cx;
    f3_d.cy       = f2_q.cy;
    f3_d.cz       = f2_q.cz;
    f3_d.c_zero   = f2_q.c_zero;
  end

  always_comb begin
    f4_d        = f3_q;
    f4_d.rem_re = {{DivFrac{1'b0}}, f3_q.n_re_mag[ProdW-1:DivFrac]};
    f4_d.rem_im = {{DivFrac{1'b0}}, f3_q.n_im_mag[ProdW-1:DivFrac]};
    f4_d.ovf_re = ({{DivFrac{1'b0}}, f3_q.n_re_mag[ProdW-1:DivFrac]} >= f3_q.d);
    f4_d.ovf_im = ({{DivFrac{1'b0}}, f3_q.n_im_mag[ProdW-1:DivFrac]} >= f3_q.d);
    f4_d.q_re   = '0;
    f4_d.q_im   = '0;
    f4_d.sq_res = '0;
    f4_d.sq_rem = f3_q.n_re_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= req_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && req_i.valid) f1_q <= f1_d;
    if (rdy2 && v1_q)        f2_q <= f2_d;
    if (rdy3 && v2_q)        f3_q <= f3_d;
    if (rdy4 && v3_q)        f4_q <= f4_d;
  end

endmodule

FILE: sv/cau_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_iter
// One iteration stage: a restoring divide step for both quotient parts,
// a square root step while STEP < SqrtSteps and a CORDIC vectoring step while STEP < CordicSteps.
// ----------------------------------------------------------------------------
module cau_iter import cau_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  output logic  rdy_o,
  input  iter_t data_i,
  output logic  vld_o,
  input  logic  rdy_i,
  output iter_t data_o
);

  localparam int DivBit = QuotW - 1 - STEP;
  localparam int SqBit  = (STEP < SqrtSteps) ? (ProdW - 2 - 2 * STEP) : 0;

  // returns {quotient bit, new remainder}
  function automatic logic [ProdW:0] div_step(input logic [ProdW-1:0] rem,
                                              input logic [ProdW-1:0] d,
                                              input logic             lin);
    logic [ProdW+1:0] tr;
    logic [ProdW:0]   r;
    tr = {1'b0, rem, lin} - {2'b00, d};
    if (!tr[ProdW+1]) begin
      r = {1'b1, tr[ProdW-1:0]};
    end else begin
      r = {1'b0, rem[ProdW-2:0], lin};
    end
    return r;
  endfunction

  logic             lin_re, lin_im;
  logic [ProdW:0]   dr_re, dr_im;
  logic [ProdW-1:0] sq_bit, sq_try;
  logic [ProdW:0]   sq_diff;
  logic signed [CordW-1:0] xs, ys;
  iter_t            n;
  iter_t            data_q;
  logic             v_q;

  if (DivBit >= int'(DivFrac)) begin : g_lin
    assign lin_re = data_i.n_re_mag[DivBit - DivFrac];
    assign lin_im = data_i.n_im_mag[DivBit - DivFrac];
  end else begin : g_nolin
    assign lin_re = 1'b0;
    assign lin_im = 1'b0;
  end

  always_comb begin
    n        = data_i;
    dr_re    = div_step(data_i.rem_re, data_i.d, lin_re);
    dr_im    = div_step(data_i.rem_im, data_i.d, lin_im);
    n.rem_re = dr_re[ProdW-1:0];
    n.rem_im = dr_im[ProdW-1:0];
    n.q_re   = {data_i.q_re[QuotW-2:0], dr_re[ProdW]};
    n.q_im   = {data_i.q_im[QuotW-2:0], dr_im[ProdW]};

    sq_bit  = ProdW'(1) << SqBit;
    sq_try  = data_i.sq_res | sq_bit;
    sq_diff = {1'b0, data_i.sq_rem} - {1'b0, sq_try};
    if (STEP < SqrtSteps) begin
      if (!sq_diff[ProdW]) begin
        n.sq_rem = sq_diff[ProdW-1:0];
        n.sq_res = (data_i.sq_res >> 1) | sq_bit;
      end else begin
        n.sq_res = data_i.sq_res >> 1;
      end
    end

    xs = data_i.cx >>> STEP;
    ys = data_i.cy >>> STEP;
    if (STEP < CordicSteps) begin
      if (!data_i.cy[CordW-1]) begin
        n.cx = data_i.cx + ys;
        n.cy = data_i.cy - xs;
        n.cz = data_i.cz + atan_lut(STEP);
      end else begin
        n.cx = data_i.cx - ys;
        n.cy = data_i.cy + xs;
        n.cz = data_i.cz - atan_lut(STEP);
      end
    end
  end

  assign rdy_o  = !v_q || rdy_i;
  assign vld_o  = v_q;
  assign data_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy_o) begin
      v_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) data_q <= n;
  end

endmodule

FILE: sv/cau_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_post
// Final rounding, clipping and result selection into the output register.
// ----------------------------------------------------------------------------
module cau_post import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  output logic  rdy_o,
  input  iter_t data_i,
  cau_rsp_if.source rsp_o
);

  logic [SumW-1:0]  mul_re, mul_im;
  logic [QuotW:0]   dq_re, dq_im;
  logic [RndW-1:0]  dm_re, dm_im;
  logic [QuotW-1:0] sq_m;
  logic             z_neg;
  logic [AngW-1:0]  z_mag;
  logic [AngW:0]    z_rnd;
  logic [DataW:0]   r0, r1;
  logic [DataW-1:0] re_d, im_d;
  logic             dz_d, sat_d;
  logic             v_q;

  always_comb begin
    mul_re = {1'b0, data_i.n_re_mag} + SumW'(32768);
    mul_im = {1'b0, data_i.n_im_mag} + SumW'(32768);
    dq_re  = {1'b0, data_i.q_re} + (QuotW+1)'(1);
    dq_im  = {1'b0, data_i.q_im} + (QuotW+1)'(1);
    dm_re  = data_i.ovf_re ? (RndW'(1) << 40) : RndW'(dq_re[QuotW:1]);
    dm_im  = data_i.ovf_im ? (RndW'(1) << 40) : RndW'(dq_im[QuotW:1]);
    sq_m   = {1'b0, data_i.sq_res[QuotW-2:0]}
             + QuotW'(data_i.sq_rem > data_i.sq_res);
    z_neg  = data_i.cz[AngW-1];
    z_mag  = z_neg ? AngW'(-data_i.cz) : AngW'(data_i.cz);
    z_rnd  = {1'b0, z_mag} + (AngW+1)'(8);

    re_d  = '0;
    im_d  = '0;
    dz_d  = 1'b0;
    sat_d = 1'b0;
    r0    = '0;
    r1    = '0;
    case (data_i.act)
      ACT_ADD, ACT_SUB: begin
        re_d  = data_i.as_re;
        im_d  = data_i.as_im;
        sat_d = data_i.as_sat;
      end
      ACT_MUL: begin
        r0    = sm_to_q(data_i.n_re_neg, mul_re[SumW-1:16]);
        r1    = sm_to_q(data_i.n_im_neg, mul_im[SumW-1:16]);
        re_d  = r0[DataW-1:0];
        im_d  = r1[DataW-1:0];
        sat_d = r0[DataW] | r1[DataW];
      end
      ACT_DIV: begin
        if (data_i.dz) begin
          dz_d = 1'b1;
        end else begin
          r0    = sm_to_q(data_i.n_re_neg, dm_re);
          r1    = sm_to_q(data_i.n_im_neg, dm_im);
          re_d  = r0[DataW-1:0];
          im_d  = r1[DataW-1:0];
          sat_d = r0[DataW] | r1[DataW];
        end
      end
      ACT_MOD: begin
        if (sq_m[QuotW-1:DataW-1] != '0) begin
          re_d  = {1'b0, {(DataW-1){1'b1}}};
          sat_d = 1'b1;
        end else begin
          re_d  = sq_m[DataW-1:0];
        end
      end
      ACT_ARG: begin
        if (!data_i.c_zero) begin
          r0    = sm_to_q(z_neg, RndW'(z_rnd[AngW:4]));
          re_d  = r0[DataW-1:0];
          sat_d = r0[DataW];
        end
      end
      default: begin
      end
    endcase
  end

  assign rdy_o       = !v_q || rsp_o.ready;
  assign rsp_o.valid = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy_o) begin
      v_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      rsp_o.res_re      <= re_d;
      rsp_o.res_im      <= im_d;
      rsp_o.div_by_zero <= dz_d;
      rsp_o.saturated   <= sat_d;
    end
  end

endmodule

FILE: sv/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex ALU on signed Q16.16: add, subtract, multiply, divide, modulus and
// argument, with saturation and divide-by-zero flags.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    action, a_re, a_im, b_re, b_im
//   rsp_o    out  valid/ready    res_re, res_im, div_by_zero, saturated
//
// Four front stages, 34 iteration stages set by the quotient bits of the
// restoring divider, one output stage; one item per cycle sustained while
// the receiver is ready. Each stage holds its item and takes a new one
// when empty or when the next stage takes its item, so bubbles close up.
// Reset clears only the stage valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_req_if.sink   req_i,
  cau_rsp_if.source rsp_o
);

  iter_t data  [IterStages+1];
  logic  vld   [IterStages+1];
  logic  rdy   [IterStages+1];

  cau_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .vld_o  (vld[0]),
    .rdy_i  (rdy[0]),
    .data_o (data[0])
  );

  for (genvar k = 0; k < IterStages; k++) begin : g_iter
    cau_iter #(
      .STEP (k)
    ) u_iter (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[k]),
      .rdy_o  (rdy[k]),
      .data_i (data[k]),
      .vld_o  (vld[k+1]),
      .rdy_i  (rdy[k+1]),
      .data_o (data[k+1])
    );
  end

  cau_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld[IterStages]),
    .rdy_o  (rdy[IterStages]),
    .data_i (data[IterStages]),
    .rsp_o  (rsp_o)
  );

endmodule

FILE: tb/sv/cau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Watches the operation and result channels of the complex arithmetic unit,
// computes the expected result of every accepted operation item and compares
// the result items field by field, in order.
// ----------------------------------------------------------------------------
module cau_checker import cau_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  cau_req_if      req_i,
  cau_rsp_if      rsp_i,
  output int      fail_count_o,
  output int      pending_o
);

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        sat;
  } cres_t;

  cres_t expected_q[$];
  int    fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic logic [31:0] clip_q(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // sign/magnitude value to Q16.16 with clipping
  function automatic logic [31:0] mag_to_q(input logic neg, input logic [65:0] mag,
                                           inout logic sat);
    if (neg) begin
      if (mag > 66'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(66'd0 - mag);
    end
    if (mag > 66'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  function automatic logic [65:0] abs66(input logic signed [65:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [65:0] div_round(input logic [65:0] n, input logic [65:0] d);
    logic [81:0] nw;
    logic [81:0] dw;
    logic [81:0] q;
    logic [81:0] r;
    nw = {16'h0, n};
    dw = {16'h0, d};
    q  = nw / dw;
    if (q >= 82'h1_0000_0000) return 66'h100_0000_0000;
    q = (nw << 16) / dw;
    r = (nw << 16) % dw;
    if ((r << 1) >= dw) q++;
    return q[65:0];
  endfunction

  function automatic logic [63:0] sqrt_round(input logic [63:0] s);
    logic [65:0] res;
    logic [65:0] bitv;
    logic [65:0] rem;
    res  = 0;
    rem  = s;
    bitv = 66'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (rem > res) res++;
    return res[63:0];
  endfunction

  function automatic longint vector_angle(input longint y0, input longint x0);
    longint x;
    longint y;
    longint z;
    longint t;
    longint xs;
    longint ys;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = ANG_HALF_PI;
      end else begin
        x = -y;
        y = t;
        z = -ANG_HALF_PI;
      end
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += atan_lut(i);
      end else begin
        x -= ys;
        y += xs;
        z -= atan_lut(i);
      end
    end
    return z;
  endfunction

  function automatic cres_t predict_result(input logic [2:0] act, input logic signed [31:0] ar,
                                           input logic signed [31:0] ai,
                                           input logic signed [31:0] br,
                                           input logic signed [31:0] bi);
    cres_t r;
    logic signed [65:0] pr;
    logic signed [65:0] pi;
    logic [65:0] d;
    logic [65:0] m;
    longint z;
    r = '{re: 0, im: 0, dz: 0, sat: 0};
    case (act)
      ACT_ADD: begin
        r.re = clip_q(longint'(ar) + br, r.sat);
        r.im = clip_q(longint'(ai) + bi, r.sat);
      end
      ACT_SUB: begin
        r.re = clip_q(longint'(ar) - br, r.sat);
        r.im = clip_q(longint'(ai) - bi, r.sat);
      end
      ACT_MUL: begin
        pr = 66'(ar) * br - 66'(ai) * bi;
        pi = 66'(ar) * bi + 66'(ai) * br;
        r.re = mag_to_q(pr < 0, (abs66(pr) + 32768) >> 16, r.sat);
        r.im = mag_to_q(pi < 0, (abs66(pi) + 32768) >> 16, r.sat);
      end
      ACT_DIV: begin
        d = 66'(br) * br + 66'(bi) * bi;
        if (d == 0) begin
          r.dz = 1'b1;
        end else begin
          pr = 66'(ar) * br + 66'(ai) * bi;
          pi = 66'(ai) * br - 66'(ar) * bi;
          r.re = mag_to_q(pr < 0, div_round(abs66(pr), d), r.sat);
          r.im = mag_to_q(pi < 0, div_round(abs66(pi), d), r.sat);
        end
      end
      ACT_MOD: begin
        m = sqrt_round(64'(66'(ar) * ar + 66'(ai) * ai));
        if (m > 66'h7FFF_FFFF) begin
          m = 66'h7FFF_FFFF;
          r.sat = 1'b1;
        end
        r.re = m[31:0];
      end
      ACT_ARG: begin
        z = vector_angle(ai, ar);
        r.re = mag_to_q(z < 0, ((z < 0 ? -z : z) + 8) >> 4, r.sat);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cres_t e;
    if (!rst_ni) begin
      fails <= 0;
      expected_q.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        expected_q.push_back(predict_result(req_i.action, req_i.a_re, req_i.a_im,
                                            req_i.b_re, req_i.b_im));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          if (fails < 10) $display("unexpected result item re=%h im=%h", rsp_i.res_re,
                                   rsp_i.res_im);
          fails <= fails + 1;
        end else begin
          e = expected_q.pop_front();
          if (rsp_i.res_re !== e.re || rsp_i.res_im !== e.im ||
              rsp_i.div_by_zero !== e.dz || rsp_i.saturated !== e.sat) begin
            if (fails < 10) begin
              $display("exp re=%h im=%h dz=%b sat=%b  got re=%h im=%h dz=%b sat=%b",
                       e.re, e.im, e.dz, e.sat, rsp_i.res_re, rsp_i.res_im,
                       rsp_i.div_by_zero, rsp_i.saturated);
            end
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random operation items into the complex arithmetic
// unit with random gaps and receiver stalls; the checker predicts and
// compares every result item.
// ----------------------------------------------------------------------------
module testbench;
  import cau_pkg::*;

  localparam int Latency  = 39;
  localparam int WdLimit  = 5000;
  localparam int NumRand  = 700;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   hold_rsp;
  bit   stim_done;

  cau_req_if req();
  cau_rsp_if rsp();

  complex_arithmetic_unit uut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));
  cau_checker chk (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_i(rsp),
                   .fail_count_o(fail_count), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 2) - 1;
      3: return 32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
      4: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(input logic [2:0] act, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi);
    int g;
    g = gap_len();
    repeat (g) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid  <= 1'b1;
    req.action <= act;
    req.a_re   <= ar;
    req.a_im   <= ai;
    req.b_re   <= br;
    req.b_im   <= bi;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [2:0] act;
    logic [31:0] br;
    logic [31:0] bi;
    act = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    br  = rand_operand();
    bi  = rand_operand();
    if (act == ACT_DIV && $urandom_range(0, 15) == 0) begin
      br = 0;
      bi = 0;
    end
    send_op(act, rand_operand(), rand_operand(), br, bi);
  endtask

  // receiver stalls; one long hold-off driven by hold_rsp
  initial begin
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (150) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else if (stim_done || $urandom_range(0, 2) != 0) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WdLimit) begin
        $display("complex_arithmetic_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    hold_rsp   = 1'b0;
    stim_done  = 1'b0;
    req.valid  <= 1'b0;
    req.action <= '0;
    req.a_re   <= '0;
    req.a_im   <= '0;
    req.b_re   <= '0;
    req.b_im   <= '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_op(ACT_ADD, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000, 32'h0003_0000);
    send_op(ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_op(ACT_SUB, 32'h0005_0000, 32'h0000_0000, 32'h0002_0000, 32'h0001_0000);
    send_op(ACT_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000);
    send_op(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_op(ACT_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(ACT_MUL, 32'h0000_0001, 32'h0000_0001, 32'h0000_8000, 32'hFFFF_8000);
    send_op(ACT_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
    send_op(ACT_DIV, 32'h0004_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000);
    send_op(ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    send_op(ACT_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_op(ACT_DIV, 32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(ACT_MOD, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_FFFF, 32'h1234_5678);
    send_op(ACT_MOD, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_op(ACT_MOD, 32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0);
    send_op(ACT_ARG, 32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0);
    send_op(ACT_ARG, 32'hFFFF_0000, 32'h0000_0000, 32'h0, 32'h0);
    send_op(ACT_ARG, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_op(ACT_ARG, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_op(ACT_ARG, 32'h0000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_op(3'd6, 32'h1234_5678, 32'h1, 32'h2, 32'h3);
    send_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int n = 0; n < NumRand; n++) begin
      if (n == 200) hold_rsp = 1'b1;
      if (n == 450) begin
        req.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      send_random();
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;

    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("complex_arithmetic_unit: match");
    end else begin
      $display("complex_arithmetic_unit: mismatch");
    end
    $finish;
  end

endmodule
